// ===== src/rthv_pkg.sv =====
// ----------------------------------------------------------------------------
// rthv_pkg: shared types and helpers for the RGB to HSV converter
// Pixel beat types, pipeline payload and one radix-4 long-division step.
// ----------------------------------------------------------------------------
package rthv_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned HueW    = 9;
  localparam int unsigned DivSteps = 2;   // quotient bits resolved per stage

  localparam logic [HueW-1:0] HueGreen = HueW'(120);
  localparam logic [HueW-1:0] HueBlue  = HueW'(240);
  localparam logic [HueW-1:0] HueWrap  = HueW'(360);

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [ChanW-1:0] saturation;
    logic [ChanW-1:0] brightness;
  } hsv_t;

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } max_sel_e;

  // Long division state: partial remainder, dividend bits still to bring
  // down, and quotient bits collected so far.
  typedef struct packed {
    logic [ChanW-1:0] rem;
    logic [ChanW-1:0] low;
    logic [ChanW-1:0] quo;
  } div_t;

  typedef struct packed {
    logic             grey;
    max_sel_e         sel;
    logic             neg;
    logic [ChanW-1:0] vmax;
    logic [ChanW-1:0] spread;
    div_t             sat;
    div_t             hue;
  } pipe_t;

  // Two restoring steps. The quotient is known to fit in ChanW bits, so the
  // remainder always stays below the divisor.
  function automatic div_t div_step(div_t s, logic [ChanW-1:0] d);
    div_t         r;
    logic [ChanW:0] part;
    r = s;
    for (int i = 0; i < DivSteps; i++) begin
      part = {r.rem, r.low[ChanW-1]};
      r.low = {r.low[ChanW-2:0], 1'b0};
      if (part >= {1'b0, d}) begin
        part  = part - {1'b0, d};
        r.quo = {r.quo[ChanW-2:0], 1'b1};
      end else begin
        r.quo = {r.quo[ChanW-2:0], 1'b0};
      end
      r.rem = part[ChanW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/rgb_to_hsv_converter_top.sv =====
// Pipeline: compare stage, four division stages at two quotient bits each,
// hue assembly / output register.
// Throughput: one pixel per cycle while the output is not stalled; the whole pipe
// holds while an output beat is stalled, so the stall depth is set by the output register.
// Reset: asynchronous, active low; clears all stage valid bits, no payload.
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_top: RGB888 to integer HSV converter
// Pipelined conversion of one pixel per clock, while the output is not stalled, with valid/ready on both sides.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_top import rthv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  rgb_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output hsv_t out_data_o
);

  localparam int unsigned NumDiv = ChanW / DivSteps;

  logic  en;
  logic  valid [NumDiv+1];
  pipe_t pipe  [NumDiv+1];

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  rthv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .pix_i   (in_data_i),
    .valid_o (valid[0]),
    .pipe_o  (pipe[0])
  );

  for (genvar i = 0; i < NumDiv; i++) begin : g_div
    rthv_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid[i]),
      .pipe_i  (pipe[i]),
      .valid_o (valid[i+1]),
      .pipe_o  (pipe[i+1])
    );
  end

  rthv_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid[NumDiv]),
    .pipe_i  (pipe[NumDiv]),
    .valid_o (out_valid_o),
    .hsv_o   (out_data_o)
  );

endmodule

// ===== src/rthv_front.sv =====
// ----------------------------------------------------------------------------
// rthv_front: channel compare stage
// Finds max, min and winning channel, forms both dividends and registers them.
// ----------------------------------------------------------------------------
module rthv_front import rthv_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  rgb_t  pix_i,
  output logic  valid_o,
  output pipe_t pipe_o
);

  logic [ChanW-1:0]   r, g, b, vmax, vmin, spread, a_op, b_op, mag;
  logic [2*ChanW-1:0] sat_num, hue_num;
  max_sel_e           sel;
  logic               neg;
  pipe_t              pipe_d, pipe_q;
  logic               valid_q;

  always_comb begin
    r = pix_i.red;
    g = pix_i.green;
    b = pix_i.blue;
    // ties go to red, then green
    if (r >= g && r >= b) begin
      sel  = MAX_RED;
      vmax = r;
      a_op = g;
      b_op = b;
    end else if (g >= b) begin
      sel  = MAX_GREEN;
      vmax = g;
      a_op = b;
      b_op = r;
    end else begin
      sel  = MAX_BLUE;
      vmax = b;
      a_op = r;
      b_op = g;
    end
    vmin = (r <= g) ? ((r <= b) ? r : b) : ((g <= b) ? g : b);
    spread = vmax - vmin;
    neg = a_op < b_op;
    mag = neg ? (b_op - a_op) : (a_op - b_op);
    // spread*255 and mag*60 by shift and subtract
    sat_num = {spread, {ChanW{1'b0}}} - {{ChanW{1'b0}}, spread};
    hue_num = {2'b00, mag, 6'b000000} - {6'b000000, mag, 2'b00};

    pipe_d.grey    = (spread == '0);
    pipe_d.sel     = sel;
    pipe_d.neg     = neg;
    pipe_d.vmax    = vmax;
    pipe_d.spread  = spread;
    pipe_d.sat.rem = sat_num[2*ChanW-1:ChanW];
    pipe_d.sat.low = sat_num[ChanW-1:0];
    pipe_d.sat.quo = '0;
    pipe_d.hue.rem = hue_num[2*ChanW-1:ChanW];
    pipe_d.hue.low = hue_num[ChanW-1:0];
    pipe_d.hue.quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

// ===== src/rthv_div_stage.sv =====
// ----------------------------------------------------------------------------
// rthv_div_stage: one division stage
// Resolves two quotient bits of both the saturation and hue divisions.
// ----------------------------------------------------------------------------
module rthv_div_stage import rthv_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  pipe_t pipe_i,
  output logic  valid_o,
  output pipe_t pipe_o
);

  pipe_t pipe_d, pipe_q;
  logic  valid_q;

  always_comb begin
    pipe_d     = pipe_i;
    // grey beats divide by zero here; the result is discarded at the end
    pipe_d.sat = div_step(pipe_i.sat, pipe_i.vmax);
    pipe_d.hue = div_step(pipe_i.hue, pipe_i.spread);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

// ===== src/rthv_back.sv =====
// ----------------------------------------------------------------------------
// rthv_back: hue assembly and output register
// Applies the sector offset and wrap, forces hue and saturation of grey pixels to zero.
// ----------------------------------------------------------------------------
module rthv_back import rthv_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  pipe_t pipe_i,
  output logic  valid_o,
  output hsv_t  hsv_o
);

  logic [HueW-1:0] q, base;
  hsv_t            hsv_d, hsv_q;
  logic            valid_q;

  always_comb begin
    q = {1'b0, pipe_i.hue.quo};
    unique case (pipe_i.sel)
      MAX_GREEN: base = HueGreen;
      MAX_BLUE:  base = HueBlue;
      // a negative difference that truncates to zero gives hue zero, no wrap
      default:   base = (pipe_i.neg && q != '0) ? HueWrap : '0;
    endcase
    hsv_d.brightness = pipe_i.vmax;
    if (pipe_i.grey) begin
      hsv_d.hue        = '0;
      hsv_d.saturation = '0;
    end else begin
      hsv_d.hue        = pipe_i.neg ? (base - q) : (base + q);
      hsv_d.saturation = pipe_i.sat.quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hsv_q <= hsv_d;
    end
  end

  assign valid_o = valid_q;
  assign hsv_o   = hsv_q;

endmodule

// ===== src/rthv_checker.sv =====
// ----------------------------------------------------------------------------
// rthv_checker: port-level checks for the RGB to HSV converter
// Output beat holding and range relations between the result fields.
// ----------------------------------------------------------------------------
module rthv_checker import rthv_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input hsv_t out_data_o
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat dropped or changed while stalled");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.hue < HueWrap)
    else $error("hue out of range");

  // any non-zero spread gives saturation of at least one
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturation == '0 |-> out_data_o.hue == '0)
    else $error("zero saturation with non-zero hue");

  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.brightness == '0 |-> out_data_o.saturation == '0)
    else $error("black pixel with non-zero saturation");

  // input back-pressure only comes from a held output beat
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output stall");

endmodule

bind rgb_to_hsv_converter_top rthv_checker u_rthv_checker (.*);
